/* hdl/sas_pkg.sv */
// Shared types and constants for the shape area sorter.
package sas_pkg;

    localparam int AREA_W  = 28;
    localparam int ENTRY_W = 31;

    localparam logic [1:0] MODE_RECT = 2'd0;
    localparam logic [1:0] MODE_CIRC = 2'd1;
    localparam logic [1:0] MODE_TRI  = 2'd2;

    // pi in Q16, times four for quarter units, then >> 14
    localparam logic [17:0] PI_Q16     = 18'd205887;
    localparam int          CIRC_SHIFT = 14;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_STAGE1,
        ST_STAGE2,
        ST_SQRT,
        ST_STORE,
        ST_CHECK,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } sas_state_t;

    typedef struct packed {
        logic load;
        logic stage1;
        logic stage2;
        logic sqrt_step;
        logic store;
        logic clear_run;
        logic scan_start;
        logic scan_step;
        logic emit;
    } sas_cmd_t;

    typedef struct packed {
        logic last;
        logic tri_run;
        logic sqrt_last;
        logic empty;
        logic scan_last;
        logic final_pick;
    } sas_status_t;

endpackage

/* hdl/shape_area_sorter.sv */
// Top level of the shape area sorter.
// One shape is taken per start while busy is low. A rectangle, a circle, an
// unused mode or a degenerate triangle passes from the area stages straight
// to the store; a proper triangle also runs a 28-step bit-serial square root
// (at DIM_BITS=12) first. busy stays high until the shape has been handled.
// On a last shape with N stored entries, results come out by a repeated
// minimum search over the store's single read port, one full scan per result.
// Each result appears for one cycle with result_valid high; the receiver
// cannot stall it, and final_result marks the last transfer of the run.
module shape_area_sorter
    import sas_pkg::*;
#(
    parameter int MAX_SHAPES = 64,
    parameter int DIM_BITS   = 12
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        mode,
    input  logic [11:0]       side_a,
    input  logic [11:0]       side_b,
    input  logic [11:0]       side_c,
    input  logic              last_shape,
    output logic              result_valid,
    output logic [1:0]        shape_kind,
    output logic [AREA_W-1:0] area_quarters,
    output logic              degenerate,
    output logic              dropped_any,
    output logic              final_result
);

    sas_cmd_t    cmd;
    sas_status_t status;

    sas_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .busy   (busy),
        .cmd    (cmd)
    );

    sas_datapath #(
        .MAX_SHAPES (MAX_SHAPES),
        .DIM_BITS   (DIM_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .mode          (mode),
        .side_a        (side_a),
        .side_b        (side_b),
        .side_c        (side_c),
        .last_shape    (last_shape),
        .result_valid  (result_valid),
        .shape_kind    (shape_kind),
        .area_quarters (area_quarters),
        .degenerate    (degenerate),
        .dropped_any   (dropped_any),
        .final_result  (final_result)
    );

endmodule

/* hdl/sas_ctrl.sv */
// Sequencer for area calculation, storing and sorted output.
module sas_ctrl
    import sas_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  sas_status_t status,
    output logic        busy,
    output sas_cmd_t    cmd
);

    sas_state_t state_reg;
    sas_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_STAGE1;
                end
            end
            ST_STAGE1:
            begin
                cmd.stage1 = 1'b1;
                state_next = ST_STAGE2;
            end
            ST_STAGE2:
            begin
                cmd.stage2 = 1'b1;
                state_next = status.tri_run ? ST_SQRT : ST_STORE;
            end
            ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (status.sqrt_last)
                begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE:
            begin
                cmd.store  = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (!status.last)
                begin
                    state_next = ST_IDLE;
                end
                else if (status.empty)
                begin
                    cmd.clear_run = 1'b1;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                cmd.emit = 1'b1;
                if (status.final_pick)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* hdl/sas_datapath.sv */
// Area arithmetic, square root unit, shape store and minimum search.
module sas_datapath
    import sas_pkg::*;
#(
    parameter int MAX_SHAPES = 64,
    parameter int DIM_BITS   = 12
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  sas_cmd_t            cmd,
    output sas_status_t         status,
    input  logic [1:0]          mode,
    input  logic [11:0]         side_a,
    input  logic [11:0]         side_b,
    input  logic [11:0]         side_c,
    input  logic                last_shape,
    output logic                result_valid,
    output logic [1:0]          shape_kind,
    output logic [AREA_W-1:0]   area_quarters,
    output logic                degenerate,
    output logic                dropped_any,
    output logic                final_result
);

    localparam int IDX_W  = (MAX_SHAPES > 1) ? $clog2(MAX_SHAPES) : 1;
    localparam int CNT_W  = $clog2(MAX_SHAPES + 1);
    localparam int F_W    = DIM_BITS + 2;
    localparam int P_W    = 2 * F_W;
    localparam int RAD_W  = 2 * P_W;
    localparam int ROOT_W = P_W;
    localparam int SC_W   = $clog2(ROOT_W);

    logic [1:0]          mode_reg;
    logic [DIM_BITS-1:0] a_reg, b_reg, c_reg;
    logic                last_reg;

    logic [2*DIM_BITS-1:0] ab_reg, aa_reg;
    logic [P_W-1:0]        p01_reg, p23_reg;
    logic                  tri_ok_reg;
    logic [AREA_W-1:0]     area_reg;

    logic [RAD_W-1:0]    rad_reg;
    logic [ROOT_W+1:0]   rem_reg;
    logic [ROOT_W-1:0]   root_reg;
    logic [SC_W-1:0]     sc_reg;

    logic [ENTRY_W-1:0]    store_mem [MAX_SHAPES];
    logic [ENTRY_W-1:0]    rd_reg;
    logic [CNT_W-1:0]      count_reg;
    logic                  overflow_reg;
    logic [MAX_SHAPES-1:0] marks_reg;

    logic [IDX_W-1:0]  addr_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic              pend_reg;
    logic              found_reg;
    logic [IDX_W-1:0]  best_idx_reg;
    logic [ENTRY_W-1:0] best_reg;
    logic [CNT_W-1:0]  k_reg;

    logic signed [F_W:0] sa, sb, sc, f0, f1, f2, f3;
    logic                tri_ok;
    logic [2*DIM_BITS+17:0] circ_full;
    logic [63:0]         ext_area;
    logic [ROOT_W+1:0]   rem_sh, trial;
    logic [ENTRY_W-1:0]  entry;
    logic                valid_mode;
    logic                better;

    assign sa = $signed({2'b00, a_reg});
    assign sb = $signed({2'b00, b_reg});
    assign sc = $signed({2'b00, c_reg});
    assign f0 = sa + sb + sc;
    assign f1 = sb + sc - sa;
    assign f2 = sa - sb + sc;
    assign f3 = sa + sb - sc;
    assign tri_ok = (f0 > 0) && (f1 > 0) && (f2 > 0) && (f3 > 0);

    assign circ_full = aa_reg * PI_Q16;

    assign rem_sh = {rem_reg[ROOT_W-1:0], rad_reg[RAD_W-1 -: 2]};
    assign trial  = {root_reg, 2'b01};

    assign valid_mode = (mode_reg == MODE_RECT) || (mode_reg == MODE_CIRC)
                        || (mode_reg == MODE_TRI);

    always_comb
    begin
        ext_area = 64'(area_reg);
        if ((mode_reg == MODE_TRI) && tri_ok_reg)
        begin
            ext_area = 64'(root_reg);
        end
        entry = {mode_reg, (mode_reg == MODE_TRI) && !tri_ok_reg, ext_area[AREA_W-1:0]};
    end

    assign better = pend_reg && !marks_reg[idx_reg]
                    && (!found_reg || (rd_reg[AREA_W-1:0] < best_reg[AREA_W-1:0]));

    assign status.last       = last_reg;
    assign status.tri_run    = (mode_reg == MODE_TRI) && tri_ok_reg;
    assign status.sqrt_last  = (sc_reg == SC_W'(ROOT_W - 1));
    assign status.empty      = (count_reg == '0);
    assign status.scan_last  = (CNT_W'(addr_reg) + CNT_W'(1) == count_reg);
    assign status.final_pick = (k_reg + CNT_W'(1) == count_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= mode;
            a_reg    <= side_a[DIM_BITS-1:0];
            b_reg    <= side_b[DIM_BITS-1:0];
            c_reg    <= side_c[DIM_BITS-1:0];
            last_reg <= last_shape;
        end
        if (cmd.stage1)
        begin
            ab_reg     <= a_reg * b_reg;
            aa_reg     <= a_reg * a_reg;
            p01_reg    <= f0[F_W-1:0] * f1[F_W-1:0];
            p23_reg    <= f2[F_W-1:0] * f3[F_W-1:0];
            tri_ok_reg <= tri_ok;
        end
        if (cmd.stage2)
        begin
            rad_reg  <= p01_reg * p23_reg;
            rem_reg  <= '0;
            root_reg <= '0;
            sc_reg   <= '0;
            case (mode_reg)
                MODE_RECT: area_reg <= AREA_W'({ab_reg, 2'b00});
                MODE_CIRC: area_reg <= AREA_W'(circ_full >> CIRC_SHIFT);
                default:   area_reg <= '0;
            endcase
        end
        if (cmd.sqrt_step)
        begin
            rad_reg <= rad_reg << 2;
            sc_reg  <= sc_reg + SC_W'(1);
            if (rem_sh >= trial)
            begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
        if (cmd.store && valid_mode && (count_reg < CNT_W'(MAX_SHAPES)))
        begin
            store_mem[count_reg[IDX_W-1:0]] <= entry;
        end
        rd_reg  <= store_mem[addr_reg];
        idx_reg <= addr_reg;
        if (better)
        begin
            best_reg     <= rd_reg;
            best_idx_reg <= idx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            overflow_reg  <= 1'b0;
            marks_reg     <= '0;
            addr_reg      <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            k_reg         <= '0;
            result_valid  <= 1'b0;
            shape_kind    <= '0;
            area_quarters <= '0;
            degenerate    <= 1'b0;
            dropped_any   <= 1'b0;
            final_result  <= 1'b0;
        end
        else
        begin
            result_valid <= cmd.emit;
            pend_reg     <= cmd.scan_step;
            if (cmd.store && valid_mode)
            begin
                if (count_reg < CNT_W'(MAX_SHAPES))
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
                else
                begin
                    overflow_reg <= 1'b1;
                end
            end
            if (cmd.clear_run)
            begin
                overflow_reg <= 1'b0;
            end
            if (cmd.scan_start)
            begin
                addr_reg  <= '0;
                found_reg <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                addr_reg <= addr_reg + IDX_W'(1);
            end
            if (better)
            begin
                found_reg <= 1'b1;
            end
            if (cmd.emit)
            begin
                shape_kind    <= best_reg[ENTRY_W-1 -: 2];
                degenerate    <= best_reg[AREA_W];
                area_quarters <= best_reg[AREA_W-1:0];
                dropped_any   <= overflow_reg;
                final_result  <= status.final_pick;
                if (status.final_pick)
                begin
                    marks_reg    <= '0;
                    count_reg    <= '0;
                    overflow_reg <= 1'b0;
                    k_reg        <= '0;
                end
                else
                begin
                    marks_reg[best_idx_reg] <= 1'b1;
                    k_reg                   <= k_reg + CNT_W'(1);
                end
            end
        end
    end

    a_emit_found: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (found_reg && (k_reg < count_reg)))
        else $error("emit without a selected entry");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (CNT_W'(idx_reg) < count_reg))
        else $error("scan read beyond stored entries");

    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && status.final_pick) |=> (count_reg == '0) && (marks_reg == '0))
        else $error("run state not cleared after final result");

endmodule
